// ----- src/btc_pkg.sv -----
// Shared types, constants and arithmetic helpers for the barometric
// temperature/pressure compensation pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package btc_pkg;

    localparam int DIV_W = 32;
    localparam int IDX_W = 3;
    localparam int CFG_W = 32;

    localparam logic [IDX_W-1:0] REG_OSS     = 3'd0;
    localparam logic [IDX_W-1:0] REG_AC1_AC2 = 3'd1;
    localparam logic [IDX_W-1:0] REG_AC3_AC4 = 3'd2;
    localparam logic [IDX_W-1:0] REG_AC5_AC6 = 3'd3;
    localparam logic [IDX_W-1:0] REG_B1_B2   = 3'd4;
    localparam logic [IDX_W-1:0] REG_MC_MD   = 3'd5;

    localparam logic [31:0] C_B5_ROUND = 32'd8;
    localparam logic [31:0] C_B6_OFF   = 32'd4000;
    localparam logic [31:0] C_B7_NUM   = 32'd50000;
    localparam logic [31:0] C_B4_OFF   = 32'd32768;
    localparam logic [31:0] C_P_K1     = 32'd3038;
    localparam logic [31:0] C_P_K2     = 32'hFFFF_E343;  // -7357
    localparam logic [31:0] C_P_K3     = 32'd3791;
    localparam logic [17:0] C_P_MAX    = 18'h3FFFF;

    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [15:0] raw_pressure;
    } in_t;

    typedef struct packed {
        logic signed [15:0] temperature_tenths;
        logic        [17:0] pressure_pa;
        logic               divide_fault;
    } out_t;

    typedef struct packed {
        logic [1:0]  oss;
        logic [31:0] ac1_ac2;
        logic [31:0] ac3_ac4;
        logic [31:0] ac5_ac6;
        logic [31:0] b1_b2;
        logic [31:0] mc_md;
    } cfg_t;

    // Working set of one sample pair; each stage fills in its own fields.
    typedef struct packed {
        logic [15:0] ut;
        logic [15:0] up;
        logic [31:0] tdiff;
        logic [31:0] m5;
        logic [31:0] x1;
        logic [31:0] dvd;
        logic [31:0] dvs;
        logic        neg;
        logic        fault;
        logic        post;
        logic [15:0] tsat;
        logic [31:0] b6;
        logic [31:0] sq0;
        logic [31:0] pa2;
        logic [31:0] pa3;
        logic [31:0] mb1;
        logic [31:0] mb2;
        logic [31:0] b3;
        logic [31:0] x3b;
        logic [31:0] b4p;
        logic [31:0] b7a;
        logic [31:0] b4;
        logic [31:0] b7;
        logic [31:0] p;
        logic [31:0] sq;
        logic [31:0] m2;
        logic [31:0] m3;
        logic [17:0] pres;
    } pipe_t;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned n);
        return 32'($signed(v) >>> n);
    endfunction

    function automatic logic [15:0] sat16(input logic [31:0] v);
        logic all0;
        logic all1;
        all0 = ~|v[31:15];
        all1 = &v[31:15];
        if (all0 || all1)
            return v[15:0];
        else if (v[31])
            return 16'h8000;
        else
            return 16'h7FFF;
    endfunction

endpackage
`default_nettype wire

// ----- src/btc_div.sv -----
// Pipelined restoring unsigned divider, one quotient bit per stage.
// Carries a side word alongside each beat. Depends on btc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module btc_div #(
    parameter int W  = btc_pkg::DIV_W,
    parameter int SW = 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [W-1:0]  dividend,
    input  wire logic [W-1:0]  divisor,
    input  wire logic [SW-1:0] side_in,
    output logic               out_valid,
    output logic [W-1:0]       quotient,
    output logic [SW-1:0]      side_out
);
    logic [W-1:0]  r_reg [W];
    logic [W-1:0]  n_reg [W];
    logic [W-1:0]  q_reg [W];
    logic [W-1:0]  d_reg [W];
    logic [SW-1:0] s_reg [W];
    logic [W-1:0]  v_reg;

    for (genvar k = 0; k < W; k++) begin : g_st
        logic [W-1:0]  r_i;
        logic [W-1:0]  n_i;
        logic [W-1:0]  q_i;
        logic [W-1:0]  d_i;
        logic [SW-1:0] s_i;
        logic          v_i;
        logic [W:0]    t;

        if (k == 0) begin : g_first
            assign r_i = '0;
            assign n_i = dividend;
            assign q_i = '0;
            assign d_i = divisor;
            assign s_i = side_in;
            assign v_i = in_valid;
        end else begin : g_next
            assign r_i = r_reg[k-1];
            assign n_i = n_reg[k-1];
            assign q_i = q_reg[k-1];
            assign d_i = d_reg[k-1];
            assign s_i = s_reg[k-1];
            assign v_i = v_reg[k-1];
        end

        // trial subtract; top bit set means the divisor did not fit
        assign t = {r_i, n_i[W-1]} - {1'b0, d_i};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en)
                v_reg[k] <= v_i;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k] <= t[W] ? {r_i[W-2:0], n_i[W-1]} : t[W-1:0];
                q_reg[k] <= {q_i[W-2:0], ~t[W]};
                n_reg[k] <= {n_i[W-2:0], 1'b0};
                d_reg[k] <= d_i;
                s_reg[k] <= s_i;
            end
        end
    end

    assign out_valid = v_reg[W-1];
    assign quotient  = q_reg[W-1];
    assign side_out  = s_reg[W-1];

endmodule
`default_nettype wire

// ----- src/btc_pre.sv -----
// Front stages: raw temperature offset, AC5 product, X1 and the signed
// operands of the temperature divide. Depends on btc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module btc_pre (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire btc_pkg::in_t   in_data,
    input  wire btc_pkg::cfg_t  cfg,
    output logic                out_valid,
    output btc_pkg::pipe_t      out_data
);
    import btc_pkg::*;

    localparam int N = 3;

    pipe_t      st_reg  [N];
    pipe_t      st_next [N];
    logic [N-1:0] vld_reg;
    logic [31:0]  num;
    logic [31:0]  den;
    logic [31:0]  x1;

    always_comb
    begin
        st_next[0]       = '0;
        st_next[0].ut    = in_data.raw_temperature;
        st_next[0].up    = in_data.raw_pressure;
        st_next[0].tdiff = {16'd0, in_data.raw_temperature} - {16'd0, cfg.ac5_ac6[15:0]};

        st_next[1]    = st_reg[0];
        st_next[1].m5 = st_reg[0].tdiff * {16'd0, cfg.ac5_ac6[31:16]};

        x1  = asr(st_reg[1].m5, 15);
        den = x1 + sx16(cfg.mc_md[15:0]);
        num = sx16(cfg.mc_md[31:16]) << 11;
        st_next[2]       = st_reg[1];
        st_next[2].x1    = x1;
        st_next[2].dvd   = num[31] ? (32'd0 - num) : num;
        st_next[2].dvs   = den[31] ? (32'd0 - den) : den;
        st_next[2].neg   = num[31] ^ den[31];
        st_next[2].fault = (den == 32'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[N-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N; k++)
                st_reg[k] <= st_next[k];
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_data  = st_reg[N-1];

endmodule
`default_nettype wire

// ----- src/btc_mid.sv -----
// Middle stages: B5, temperature, B6 products, B3, B4, B7 and the
// operands of the pressure divide. Depends on btc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module btc_mid (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire btc_pkg::pipe_t in_data,
    input  wire logic [31:0]    quot,
    input  wire btc_pkg::cfg_t  cfg,
    output logic                out_valid,
    output btc_pkg::pipe_t      out_data
);
    import btc_pkg::*;

    localparam int N = 7;

    pipe_t        st_reg  [N];
    pipe_t        st_next [N];
    logic [N-1:0] vld_reg;
    logic [31:0]  x2;
    logic [31:0]  b5;
    logic [31:0]  b6sq;
    logic [31:0]  x3;
    logic [31:0]  v;
    logic [31:0]  b4;

    always_comb
    begin
        x2 = in_data.fault ? 32'd0 : (in_data.neg ? (32'd0 - quot) : quot);
        b5 = in_data.x1 + x2;
        st_next[0]      = in_data;
        st_next[0].tsat = sat16(asr(b5 + C_B5_ROUND, 4));
        st_next[0].b6   = b5 - C_B6_OFF;

        st_next[1]     = st_reg[0];
        st_next[1].sq0 = st_reg[0].b6 * st_reg[0].b6;
        st_next[1].pa2 = sx16(cfg.ac1_ac2[15:0]) * st_reg[0].b6;
        st_next[1].pa3 = sx16(cfg.ac3_ac4[31:16]) * st_reg[0].b6;

        b6sq = asr(st_reg[1].sq0, 12);
        st_next[2]     = st_reg[1];
        st_next[2].mb2 = sx16(cfg.b1_b2[15:0]) * b6sq;
        st_next[2].mb1 = sx16(cfg.b1_b2[31:16]) * b6sq;

        // B3: signed divide by four rounds toward zero
        x3 = asr(st_reg[2].mb2, 11) + asr(st_reg[2].pa2, 11);
        v  = (((sx16(cfg.ac1_ac2[31:16]) << 2) + x3) << cfg.oss) + 32'd2;
        st_next[3]     = st_reg[2];
        st_next[3].b3  = asr(v + (v[31] ? 32'd3 : 32'd0), 2);
        st_next[3].x3b = asr(asr(st_reg[2].pa3, 13) + asr(st_reg[2].mb1, 16) + 32'd2, 2);

        st_next[4]     = st_reg[3];
        st_next[4].b4p = {16'd0, cfg.ac3_ac4[15:0]} * (st_reg[3].x3b + C_B4_OFF);
        st_next[4].b7a = {16'd0, st_reg[3].up} - st_reg[3].b3;

        b4 = st_reg[4].b4p >> 15;
        st_next[5]       = st_reg[4];
        st_next[5].b4    = b4;
        st_next[5].b7    = st_reg[4].b7a * (C_B7_NUM >> cfg.oss);
        st_next[5].fault = st_reg[4].fault | (b4 == 32'd0);

        // double before the divide unless B7 has its top bit set
        st_next[6]      = st_reg[5];
        st_next[6].post = st_reg[5].b7[31];
        st_next[6].dvd  = st_reg[5].b7[31] ? st_reg[5].b7 : {st_reg[5].b7[30:0], 1'b0};
        st_next[6].dvs  = st_reg[5].b4;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[N-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N; k++)
                st_reg[k] <= st_next[k];
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_data  = st_reg[N-1];

endmodule
`default_nettype wire

// ----- src/btc_post.sv -----
// Final stages: pressure quotient, second-order correction and
// saturation of the pressure result. Depends on btc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module btc_post (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire btc_pkg::pipe_t in_data,
    input  wire logic [31:0]    quot,
    output logic                out_valid,
    output btc_pkg::pipe_t      out_data
);
    import btc_pkg::*;

    localparam int N = 4;

    pipe_t        st_reg  [N];
    pipe_t        st_next [N];
    logic [N-1:0] vld_reg;
    logic [31:0]  pp;
    logic [31:0]  pf;

    always_comb
    begin
        st_next[0]   = in_data;
        st_next[0].p = in_data.post ? {quot[30:0], 1'b0} : quot;

        pp = asr(st_reg[0].p, 8);
        st_next[1]    = st_reg[0];
        st_next[1].sq = pp * pp;
        st_next[1].m2 = C_P_K2 * st_reg[0].p;

        st_next[2]    = st_reg[1];
        st_next[2].m3 = st_reg[1].sq * C_P_K1;

        pf = st_reg[2].p
           + asr(asr(st_reg[2].m3, 16) + asr(st_reg[2].m2, 16) + C_P_K3, 4);
        st_next[3] = st_reg[2];
        if (st_reg[2].fault || pf[31])
            st_next[3].pres = '0;
        else if (|pf[30:18])
            st_next[3].pres = C_P_MAX;
        else
            st_next[3].pres = pf[17:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[N-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N; k++)
                st_reg[k] <= st_next[k];
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_data  = st_reg[N-1];

endmodule
`default_nettype wire

// ----- src/baro_temp_pressure_compensation.sv -----
// Top level: calibration registers, the two divider pipelines and the
// stage blocks. Depends on btc_pkg, btc_pre, btc_div, btc_mid, btc_post.
//
//   channel   signals                           direction
//   input     in_valid / in_ready / in_data     sample pair in
//   output    out_valid / out_ready / out_data  compensated result out
//   config    cfg_we / cfg_index / cfg_data     register write, no wait
//
// One sample pair enters per cycle while the output is not stalled. Each
// passes 3 front stages, 32 temperature divider stages, 7 middle stages,
// 32 pressure divider stages, 4 final stages and the output register.
// Reset clears the valid bits and the calibration registers to zero.
// A stall at the output freezes every stage at once, so no beat moves.
`timescale 1ns / 1ps
`default_nettype none
module baro_temp_pressure_compensation (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire btc_pkg::in_t                  in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output btc_pkg::out_t                      out_data,
    input  wire logic                          cfg_we,
    input  wire logic [btc_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [btc_pkg::CFG_W-1:0]     cfg_data
);
    import btc_pkg::*;

    localparam int PW = $bits(pipe_t);

    cfg_t          cfg_reg;
    logic          en;
    logic          pre_valid;
    pipe_t         pre_data;
    logic          d1_valid;
    logic [31:0]   d1_quot;
    logic [PW-1:0] d1_side;
    logic          mid_valid;
    pipe_t         mid_data;
    logic          d2_valid;
    logic [31:0]   d2_quot;
    logic [PW-1:0] d2_side;
    logic          post_valid;
    pipe_t         post_data;
    logic          out_valid_reg;
    out_t          out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OSS:     cfg_reg.oss     <= cfg_data[1:0];
                REG_AC1_AC2: cfg_reg.ac1_ac2 <= cfg_data;
                REG_AC3_AC4: cfg_reg.ac3_ac4 <= cfg_data;
                REG_AC5_AC6: cfg_reg.ac5_ac6 <= cfg_data;
                REG_B1_B2:   cfg_reg.b1_b2   <= cfg_data;
                REG_MC_MD:   cfg_reg.mc_md   <= cfg_data;
                default:     cfg_reg         <= cfg_reg;
            endcase
        end
    end

    // advance the whole pipe whenever the output slot is free or drains
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    btc_pre u_pre (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .cfg       (cfg_reg),
        .out_valid (pre_valid),
        .out_data  (pre_data)
    );

    btc_div #(.W(DIV_W), .SW(PW)) u_div_t (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pre_valid),
        .dividend  (pre_data.dvd),
        .divisor   (pre_data.dvs),
        .side_in   (PW'(pre_data)),
        .out_valid (d1_valid),
        .quotient  (d1_quot),
        .side_out  (d1_side)
    );

    btc_mid u_mid (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d1_valid),
        .in_data   (pipe_t'(d1_side)),
        .quot      (d1_quot),
        .cfg       (cfg_reg),
        .out_valid (mid_valid),
        .out_data  (mid_data)
    );

    btc_div #(.W(DIV_W), .SW(PW)) u_div_p (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mid_valid),
        .dividend  (mid_data.dvd),
        .divisor   (mid_data.dvs),
        .side_in   (PW'(mid_data)),
        .out_valid (d2_valid),
        .quotient  (d2_quot),
        .side_out  (d2_side)
    );

    btc_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d2_valid),
        .in_data   (pipe_t'(d2_side)),
        .quot      (d2_quot),
        .out_valid (post_valid),
        .out_data  (post_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= post_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg.temperature_tenths <= post_data.tsat;
            out_data_reg.pressure_pa        <= post_data.pres;
            out_data_reg.divide_fault       <= post_data.fault;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

// ----- tb/baro_temp_pressure_compensation_tb.sv -----
// Self-checking bench for the barometric compensation pipeline: random and
// directed sample pairs under several calibration sets. Depends on btc_pkg and the DUT.
`timescale 1ns / 1ps
module baro_temp_pressure_compensation_tb;
    import btc_pkg::*;

    localparam int LATENCY = 79;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;
    logic cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    baro_temp_pressure_compensation dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor's copy of the calibration.
    logic [1:0] cal_oss;
    logic [31:0] cal_regs [1:5];

    in_t pending_samples [$];
    out_t expected_readings [$];
    int accepted_count;
    int checked_count;
    int fault_count;
    int mismatch_count;
    int hold_off;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [31:0] sar(input logic [31:0] v, input int n);
        return 32'($signed(v) >>> n);
    endfunction

    function automatic logic [31:0] sdivide(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ua;
        logic [31:0] ub;
        logic [31:0] q;
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        q = ua / ub;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic out_t compensate(input in_t s);
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] x1, x2, x3, b3, b4, b5, b6, b6sq, b7, p, den, t;
        logic fault;
        out_t r;
        ac1 = {{16{cal_regs[1][31]}}, cal_regs[1][31:16]};
        ac2 = {{16{cal_regs[1][15]}}, cal_regs[1][15:0]};
        ac3 = {{16{cal_regs[2][31]}}, cal_regs[2][31:16]};
        ac4 = {16'd0, cal_regs[2][15:0]};
        ac5 = {16'd0, cal_regs[3][31:16]};
        ac6 = {16'd0, cal_regs[3][15:0]};
        b1 = {{16{cal_regs[4][31]}}, cal_regs[4][31:16]};
        b2 = {{16{cal_regs[4][15]}}, cal_regs[4][15:0]};
        mc = {{16{cal_regs[5][31]}}, cal_regs[5][31:16]};
        md = {{16{cal_regs[5][15]}}, cal_regs[5][15:0]};
        fault = 1'b0;
        x1 = sar(({16'd0, s.raw_temperature} - ac6) * ac5, 15);
        den = x1 + md;
        if (den == 0)
        begin
            fault = 1'b1;
            x2 = 0;
        end
        else
            x2 = sdivide(mc << 11, den);
        b5 = x1 + x2;
        t = sar(b5 + 32'd8, 4);
        b6 = b5 - 32'd4000;
        b6sq = sar(b6 * b6, 12);
        x1 = sar(b2 * b6sq, 11);
        x2 = sar(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = sdivide(((ac1 * 4 + x3) << cal_oss) + 32'd2, 32'd4);
        x1 = sar(ac3 * b6, 13);
        x2 = sar(b1 * b6sq, 16);
        x3 = sar(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + 32'd32768)) >> 15;
        b7 = ({16'd0, s.raw_pressure} - b3) * (32'd50000 >> cal_oss);
        p = 0;
        if (b4 == 0)
            fault = 1'b1;
        else
        begin
            if (!b7[31])
                p = (b7 * 2) / b4;
            else
                p = (b7 / b4) * 2;
            x1 = sar(p, 8) * sar(p, 8);
            x1 = sar(x1 * 32'd3038, 16);
            x2 = sar(32'hFFFF_E343 * p, 16);
            p = p + sar(x1 + x2 + 32'd3791, 4);
        end
        if ($signed(t) > 32767)
            r.temperature_tenths = 16'sh7FFF;
        else if ($signed(t) < -32768)
            r.temperature_tenths = 16'sh8000;
        else
            r.temperature_tenths = t[15:0];
        if (fault || p[31])
            r.pressure_pa = '0;
        else if (p > 32'd262143)
            r.pressure_pa = 18'h3FFFF;
        else
            r.pressure_pa = p[17:0];
        r.divide_fault = fault;
        return r;
    endfunction

    // Driver: one beat per entry, random gap before each.
    always @(posedge clk or negedge rst_n)
    begin
        static int gap = 0;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            gap = $urandom_range(0, 4);
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_readings.push_back(compensate(in_data));
                accepted_count++;
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            end
            if (!in_valid || in_ready)
            begin
                if (gap == 0 && pending_samples.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_data <= pending_samples.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (gap > 0)
                        gap--;
                end
            end
        end
    end

    // Monitor: stall at random, or for a long stretch while hold_off runs.
    always @(posedge clk or negedge rst_n)
    begin
        static int stall = 0;
        out_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected beat %p", out_data);
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (want.divide_fault)
                        fault_count++;
                    if (out_data !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("beat %0d: expected %p, got %p",
                                     checked_count, want, out_data);
                    end
                end
                checked_count++;
                stall = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 4) : 0;
            end
            if (hold_off > 0)
            begin
                hold_off--;
                out_ready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_OSS)
            cal_oss = val[1:0];
        else
            cal_regs[idx] = val;
    endtask

    task automatic drain;
        while (pending_samples.size() > 0 || in_valid || expected_readings.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic load_cal(input logic [1:0] o, input logic [31:0] r1, input logic [31:0] r2,
                            input logic [31:0] r3, input logic [31:0] r4,
                            input logic [31:0] r5);
        write_reg(REG_OSS, {30'd0, o});
        write_reg(REG_AC1_AC2, r1);
        write_reg(REG_AC3_AC4, r2);
        write_reg(REG_AC5_AC6, r3);
        write_reg(REG_B1_B2, r4);
        write_reg(REG_MC_MD, r5);
    endtask

    task automatic queue_sample(input logic [15:0] ut, input logic [15:0] up);
        in_t s;
        s.raw_temperature = ut;
        s.raw_pressure = up;
        pending_samples.push_back(s);
    endtask

    // Raw readings near a typical operating point, with full-range noise now and then.
    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++)
            if ($urandom_range(0, 3) == 0)
                queue_sample(16'($urandom), 16'($urandom));
            else
                queue_sample(16'($urandom_range(20000, 35000)),
                             16'($urandom_range(20000, 45000)));
    endtask

    initial
    begin
        logic [31:0] typical [1:5];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_off = 0;
        mismatch_count = 0;
        cal_oss = '0;
        for (int i = 1; i <= 5; i++)
            cal_regs[i] = '0;
        typical[1] = {16'd408, 16'hFE30};
        typical[2] = {16'hC6A1, 16'd32741};
        typical[3] = {16'd32757, 16'd23153};
        typical[4] = {16'd6190, 16'd4};
        typical[5] = {16'h8000, 16'd2868};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset calibration: both divisors zero, fault on every sample.
        queue_sample(16'h0000, 16'h0000);
        queue_sample(16'hFFFF, 16'hFFFF);
        drain();

        load_cal(2'd0, typical[1], typical[2], typical[3], typical[4], typical[5]);
        queue_sample(16'd27898, 16'd23843);
        queue_sample(16'h0000, 16'h0000);
        queue_sample(16'hFFFF, 16'hFFFF);
        queue_sample(16'hFFFF, 16'h0000);
        queue_sample(16'h0000, 16'hFFFF);
        queue_sample(16'h5555, 16'hAAAA);
        queue_sample(16'hAAAA, 16'h5555);
        drain();

        // Temperature divisor zero: AC5 = 0 gives X1 = 0, MD = 0.
        load_cal(2'd3, typical[1], typical[2], {16'd0, 16'd100}, typical[4],
                 {16'd1234, 16'd0});
        queue_sample(16'd27898, 16'd23843);
        queue_sample(16'hFFFF, 16'h0000);
        drain();

        // Extreme coefficients: overflow, saturation, most-negative divide.
        load_cal(2'd1, 32'h8000_8000, 32'h8000_FFFF, 32'hFFFF_FFFF,
                 32'h8000_8000, 32'h8000_FFFF);
        queue_sample(16'h0000, 16'hFFFF);
        queue_sample(16'hFFFF, 16'h0000);
        queue_sample(16'h8000, 16'h8000);
        drain();
        load_cal(2'd2, 32'h7FFF_7FFF, 32'h7FFF_FFFF, 32'hFFFF_0000,
                 32'h7FFF_7FFF, 32'h7FFF_7FFF);
        queue_sample(16'h0000, 16'hFFFF);
        queue_sample(16'hFFFF, 16'h0000);
        queue_sample(16'h1234, 16'hFEDC);
        drain();

        // Main random phases across every oversampling setting.
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph < 4)
                load_cal(2'(ph), typical[1], typical[2], typical[3], typical[4],
                         typical[5]);
            else
                load_cal(2'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom);
            queue_random(200);
            if (ph == 1)
            begin
                repeat (20) @(posedge clk);
                hold_off = 150;
            end
            drain();
        end

        $display("covered %0d samples, %0d results checked (%0d divide faults)",
                 accepted_count, checked_count, fault_count);
        $display("six calibration sets plus extremes, oss 0..3, one long output stall");
        if (mismatch_count == 0)
            $display("baro_temp_pressure_compensation: match");
        else
            $display("baro_temp_pressure_compensation: mismatch");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("baro_temp_pressure_compensation: mismatch");
        $finish;
    end
endmodule

// ----- filelist.f -----
src/btc_pkg.sv
src/btc_div.sv
src/btc_pre.sv
src/btc_mid.sv
src/btc_post.sv
src/baro_temp_pressure_compensation.sv
tb/baro_temp_pressure_compensation_tb.sv
